/* rtl/core/search_result_hash_table_unit_defines.svh */
// Assertion helpers for the RTL.
`ifndef SEARCH_RESULT_HASH_TABLE_UNIT_DEFINES_SVH
`define SEARCH_RESULT_HASH_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SRHT_ASSERT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("srht: check failed");

// Next-cycle implication, checked out of reset.
`define SRHT_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("srht: check failed");

`endif

/* rtl/core/srht_pkg.sv */
package srht_pkg;

  localparam int unsigned ENTRIES_DEF = 65536;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [14:0] MATE_THR_RESET = 15'd29936;
  localparam logic [7:0]  AGE_RESET      = 8'd0;

  localparam logic [1:0] BOUND_NONE  = 2'd0;
  localparam logic [1:0] BOUND_UPPER = 2'd1;
  localparam logic [1:0] BOUND_LOWER = 2'd2;
  localparam logic [1:0] BOUND_EXACT = 2'd3;

  typedef enum logic [1:0] {
    OP_PROBE      = 2'd0,
    OP_STORE      = 2'd1,
    OP_MOVE_PROBE = 2'd2,
    OP_CLEAR      = 2'd3
  } op_t;

  typedef enum logic {
    REG_MATE_THR = 1'b0,
    REG_AGE      = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    BK_CLEAR = 2'd0,
    BK_IDLE  = 2'd1,
    BK_EXEC  = 2'd2
  } bk_state_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [63:0]        position_key;
    logic [24:0]        move_in;
    logic signed [15:0] score_in;
    logic [1:0]         bound_kind;
    logic [7:0]         search_depth;
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
    logic [6:0]         ply;
  } in_t;

  typedef struct packed {
    logic               cutoff;
    logic               key_match;
    logic [24:0]        move_out;
    logic signed [15:0] score_out;
    logic               written;
    logic [31:0]        hits;
    logic [31:0]        new_writes;
    logic [31:0]        overwrites;
  } out_t;

  // Classified command; score_st already carries the store-side mate shift.
  typedef struct packed {
    op_t                op;
    logic [63:0]        key;
    logic [24:0]        move;
    logic signed [15:0] score_st;
    logic [1:0]         bound;
    logic [7:0]         depth;
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
    logic [6:0]         ply;
  } cmd_t;

  typedef struct packed {
    logic [63:0]        key;
    logic [24:0]        move;
    logic signed [15:0] score;
    logic [7:0]         depth;
    logic [1:0]         bound;
    logic [7:0]         age;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

endpackage

/* rtl/core/srht_ram.sv */
module srht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/srht_front.sv */
module srht_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           take,
  input  srht_pkg::in_t  in_data,
  input  logic [14:0]    mate_thr,
  input  srht_pkg::qstat_t qstat,
  output logic           push,
  output srht_pkg::cmd_t cmd,
  output logic           front_busy
);

  logic           valid_r, valid_nxt;
  srht_pkg::cmd_t cmd_r, cmd_nxt;
  srht_pkg::cmd_t cls;

  logic signed [16:0] sc_ext, thr_pos, thr_neg, ply_ext, sum_up, sum_dn;
  logic signed [15:0] sc_st;

  // store-side mate shift, saturated to 16 bits
  always_comb begin
    sc_ext  = {in_data.score_in[15], in_data.score_in};
    thr_pos = {2'b00, mate_thr};
    thr_neg = -thr_pos;
    ply_ext = {10'b0, in_data.ply};
    sum_up  = sc_ext + ply_ext;
    sum_dn  = sc_ext - ply_ext;
    if (sc_ext > thr_pos) begin
      sc_st = (sum_up > 17'sd32767) ? 16'sh7fff : sum_up[15:0];
    end else if (sc_ext < thr_neg) begin
      sc_st = (sum_dn < -17'sd32768) ? 16'sh8000 : sum_dn[15:0];
    end else begin
      sc_st = in_data.score_in;
    end
  end

  always_comb begin
    cls.op       = srht_pkg::op_t'(in_data.operation);
    cls.key      = in_data.position_key;
    cls.move     = in_data.move_in;
    cls.score_st = sc_st;
    cls.bound    = in_data.bound_kind;
    cls.depth    = in_data.search_depth;
    cls.alpha    = in_data.alpha;
    cls.beta     = in_data.beta;
    cls.ply      = in_data.ply;
  end

  assign push       = valid_r && !qstat.full;
  assign cmd        = cmd_r;
  assign front_busy = valid_r;

  always_comb begin
    valid_nxt = valid_r;
    cmd_nxt   = cmd_r;
    if (push) begin
      valid_nxt = 1'b0;
    end
    if (take) begin
      valid_nxt = 1'b1;
      cmd_nxt   = cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

endmodule

/* rtl/core/srht_queue.sv */
module srht_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  srht_pkg::cmd_t   cmd_in,
  input  logic             pop,
  output srht_pkg::cmd_t   head,
  output srht_pkg::qstat_t qstat
);

  srht_pkg::cmd_t q_r [srht_pkg::QUEUE_DEPTH];

  logic [srht_pkg::QPTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [srht_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = push ? wp_r + srht_pkg::QPTR_W'(1) : wp_r;
    rp_nxt  = pop ? rp_r + srht_pkg::QPTR_W'(1) : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + srht_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - srht_pkg::QCNT_W'(1);
    end
  end

  assign qstat.empty = (cnt_r == '0);
  assign qstat.full  = (cnt_r == srht_pkg::QCNT_W'(srht_pkg::QUEUE_DEPTH));
  assign head        = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cmd_in;
    end
  end

endmodule

/* rtl/core/srht_back.sv */
`include "search_result_hash_table_unit_defines.svh"

module srht_back #(
  parameter int unsigned ENTRIES = srht_pkg::ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  srht_pkg::qstat_t qstat,
  input  srht_pkg::cmd_t   head,
  output logic             pop,
  input  logic [14:0]      mate_thr,
  input  logic [7:0]       cur_age,
  output logic             age_clr,
  output logic             back_busy,
  output logic             out_valid,
  output srht_pkg::out_t   out_data
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);

  srht_pkg::bk_state_t state_r, state_nxt;
  logic [IDX_W-1:0]    clr_cnt_r, clr_cnt_nxt;
  srht_pkg::cmd_t      cmd_r, cmd_nxt;
  logic [31:0]         hits_r, hits_nxt, new_r, new_nxt, ovw_r, ovw_nxt;
  logic                out_valid_r, out_valid_nxt;
  srht_pkg::out_t      res_r, res_nxt;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr, ram_raddr;
  srht_pkg::entry_t    ram_wdata, ent;
  srht_pkg::entry_t    new_ent;

  srht_ram #(
    .WIDTH ($bits(srht_pkg::entry_t)),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ent)
  );

  // table read issued as the command leaves the queue
  assign ram_raddr = head.key[IDX_W-1:0];

  // entry evaluation
  logic               match, deep, empty, replace, go, cut;
  logic signed [16:0] s_ext, thr_pos, thr_neg, ply_ext, s_adj17;
  logic signed [15:0] s_adj, s_prb;

  always_comb begin
    match   = (ent.key == cmd_r.key);
    deep    = (ent.depth >= cmd_r.depth);
    empty   = (ent.key == '0);
    replace = (ent.age < cur_age) || (ent.depth < cmd_r.depth);
    go      = empty || replace;
    s_ext   = {ent.score[15], ent.score};
    thr_pos = {2'b00, mate_thr};
    thr_neg = -thr_pos;
    ply_ext = {10'b0, cmd_r.ply};
    if (s_ext > thr_pos) begin
      s_adj17 = s_ext - ply_ext;
    end else if (s_ext < thr_neg) begin
      s_adj17 = s_ext + ply_ext;
    end else begin
      s_adj17 = s_ext;
    end
    s_adj = s_adj17[15:0];
    cut   = 1'b0;
    s_prb = s_adj;
    case (ent.bound)
      srht_pkg::BOUND_UPPER: begin
        if (s_adj <= cmd_r.alpha) begin
          cut   = 1'b1;
          s_prb = cmd_r.alpha;
        end
      end
      srht_pkg::BOUND_LOWER: begin
        if (s_adj >= cmd_r.beta) begin
          cut   = 1'b1;
          s_prb = cmd_r.beta;
        end
      end
      srht_pkg::BOUND_EXACT: cut = 1'b1;
      default: cut = 1'b0;
    endcase
    new_ent.key   = cmd_r.key;
    new_ent.move  = cmd_r.move;
    new_ent.score = cmd_r.score_st;
    new_ent.depth = cmd_r.depth;
    new_ent.bound = cmd_r.bound;
    new_ent.age   = cur_age;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      srht_pkg::BK_CLEAR: begin
        if (clr_cnt_r == '1) begin
          state_nxt = srht_pkg::BK_IDLE;
        end
      end
      srht_pkg::BK_IDLE: begin
        if (!qstat.empty) begin
          state_nxt = (head.op == srht_pkg::OP_CLEAR) ? srht_pkg::BK_CLEAR : srht_pkg::BK_EXEC;
        end
      end
      srht_pkg::BK_EXEC: state_nxt = srht_pkg::BK_IDLE;
      default:           state_nxt = srht_pkg::BK_CLEAR;
    endcase
  end

  // outputs and datapath
  always_comb begin
    pop           = 1'b0;
    age_clr       = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = cmd_r.key[IDX_W-1:0];
    ram_wdata     = new_ent;
    clr_cnt_nxt   = clr_cnt_r;
    cmd_nxt       = cmd_r;
    hits_nxt      = hits_r;
    new_nxt       = new_r;
    ovw_nxt       = ovw_r;
    out_valid_nxt = 1'b0;
    res_nxt       = res_r;
    case (state_r)
      srht_pkg::BK_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + IDX_W'(1);
      end
      srht_pkg::BK_IDLE: begin
        if (!qstat.empty) begin
          pop     = 1'b1;
          cmd_nxt = head;
          if (head.op == srht_pkg::OP_CLEAR) begin
            age_clr            = 1'b1;
            clr_cnt_nxt        = '0;
            new_nxt            = '0;
            out_valid_nxt      = 1'b1;
            res_nxt            = '0;
            res_nxt.hits       = hits_r;
            res_nxt.new_writes = '0;
            res_nxt.overwrites = ovw_r;
          end
        end
      end
      srht_pkg::BK_EXEC: begin
        out_valid_nxt     = 1'b1;
        res_nxt           = '0;
        res_nxt.key_match = match;
        case (cmd_r.op)
          srht_pkg::OP_PROBE: begin
            if (match) begin
              res_nxt.move_out = ent.move;
              if (deep) begin
                hits_nxt          = hits_r + 32'd1;
                res_nxt.score_out = s_prb;
                res_nxt.cutoff    = cut;
              end
            end
          end
          srht_pkg::OP_MOVE_PROBE: begin
            if (match) begin
              res_nxt.move_out = ent.move;
            end
          end
          srht_pkg::OP_STORE: begin
            if (empty) begin
              new_nxt = new_r + 32'd1;
            end else if (replace) begin
              ovw_nxt = ovw_r + 32'd1;
            end
            ram_we          = go;
            res_nxt.written = go;
          end
          default: res_nxt.key_match = 1'b0;
        endcase
        res_nxt.hits       = hits_nxt;
        res_nxt.new_writes = new_nxt;
        res_nxt.overwrites = ovw_nxt;
      end
      default: ram_we = 1'b0;
    endcase
  end

  assign back_busy = (state_r != srht_pkg::BK_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srht_pkg::BK_CLEAR;
      clr_cnt_r   <= '0;
      hits_r      <= '0;
      new_r       <= '0;
      ovw_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      hits_r      <= hits_nxt;
      new_r       <= new_nxt;
      ovw_r       <= ovw_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    res_r <= res_nxt;
  end

  `SRHT_ASSERT(a_pop_needs_item, clk, rst_n, pop, !qstat.empty)
  `SRHT_ASSERT(a_sweep_zeroes, clk, rst_n, state_r == srht_pkg::BK_CLEAR, ram_we && (ram_wdata == '0))
  `SRHT_ASSERT_NEXT(a_exec_reports, clk, rst_n, state_r == srht_pkg::BK_EXEC, out_valid_r && (state_r == srht_pkg::BK_IDLE))
  `SRHT_ASSERT(a_write_only_store, clk, rst_n, ram_we && (state_r != srht_pkg::BK_CLEAR), (state_r == srht_pkg::BK_EXEC) && (cmd_r.op == srht_pkg::OP_STORE))

endmodule

/* rtl/core/search_result_hash_table_unit.sv */
// Direct-mapped search result table with depth/age replacement. Start a command (probe,
// store, move probe, clear) by raising start while busy is low; exactly one result comes
// back on out_data, flagged by out_valid for a single cycle, and it must be taken then:
// there is no backpressure on the result side. A probe or store goes through the front
// stage, command queue, table read, and entry check and write-back before the next
// transfer; busy drops in the cycle the result shows. The table is one single-port-write,
// registered-read RAM, so every entry is swept to zero after reset and after a clear
// command, one entry per cycle, with busy high. A clear reports its result at the start
// of the sweep. The user must write registers mate_threshold and current_age over the
// APB port only while busy is low and no result is pending; the block does not enforce it.
module search_result_hash_table_unit #(
  parameter int unsigned ENTRIES = srht_pkg::ENTRIES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  // command channel
  input  logic           start,
  input  srht_pkg::in_t  in_data,
  output logic           busy,
  // result channel
  output logic           out_valid,
  output srht_pkg::out_t out_data,
  // configuration, APB style
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  logic [14:0] mate_thr_r, mate_thr_nxt;
  logic [7:0]  age_r, age_nxt;

  logic               take, push, pop, front_busy, back_busy, age_clr;
  srht_pkg::cmd_t     cmd, head;
  srht_pkg::qstat_t   qstat;
  srht_pkg::reg_idx_t reg_idx;
  logic               cfg_wr;

  // a transfer on the command channel
  assign take = start && !busy;
  assign busy = front_busy || !qstat.empty || back_busy;

  srht_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .in_data    (in_data),
    .mate_thr   (mate_thr_r),
    .qstat      (qstat),
    .push       (push),
    .cmd        (cmd),
    .front_busy (front_busy)
  );

  srht_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .cmd_in (cmd),
    .pop    (pop),
    .head   (head),
    .qstat  (qstat)
  );

  srht_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .qstat     (qstat),
    .head      (head),
    .pop       (pop),
    .mate_thr  (mate_thr_r),
    .cur_age   (age_r),
    .age_clr   (age_clr),
    .back_busy (back_busy),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // register file: index by word address
  assign pready  = 1'b1;
  assign reg_idx = srht_pkg::reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    case (reg_idx)
      srht_pkg::REG_MATE_THR: prdata = {17'b0, mate_thr_r};
      srht_pkg::REG_AGE:      prdata = {24'b0, age_r};
      default:                prdata = '0;
    endcase
  end

  always_comb begin
    mate_thr_nxt = mate_thr_r;
    age_nxt      = age_r;
    // clear command restarts the generation count
    if (age_clr) begin
      age_nxt = '0;
    end
    if (cfg_wr) begin
      case (reg_idx)
        srht_pkg::REG_MATE_THR: mate_thr_nxt = pwdata[14:0];
        srht_pkg::REG_AGE:      age_nxt      = pwdata[7:0];
        default:                age_nxt      = age_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mate_thr_r <= srht_pkg::MATE_THR_RESET;
      age_r      <= srht_pkg::AGE_RESET;
    end else begin
      mate_thr_r <= mate_thr_nxt;
      age_r      <= age_nxt;
    end
  end

endmodule
